@@ design/opw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opw_pkg: shared types and constants of the update packet writer
// packet kinds, register indexes, command codes and the queued command record
// ----------------------------------------------------------------------------
package opw_pkg;

    // field widths fixed by the packet format
    localparam int ADDR_W       = 24;
    localparam int FLASH_ADDR_W = 25;
    localparam int DEV_W        = 8;
    localparam int VER_W        = 8;
    localparam int WORD_W       = 64;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    // packet kinds
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // configuration register indexes
    localparam logic CFG_IMAGE_BASE = 1'b0;
    localparam logic CFG_HEADER     = 1'b1;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        OP_REJECT = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_DATA   = 2'd2,
        OP_END    = 2'd3
    } opw_op_t;

    typedef struct packed {
        opw_op_t             op;
        logic                erase;
        logic [ADDR_W-1:0]   addr;
        logic [VER_W-1:0]    version;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   hi;
    } opw_cmd_t;

endpackage
`default_nettype wire

@@ design/opw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opw_front: packet intake and classification
// holds the session and the erase-pending map, turns each packet into a command
// ----------------------------------------------------------------------------
module opw_front
    import opw_pkg::*;
#(
    parameter int SECTOR_BYTES = 4096,
    parameter int MAP_SECTORS  = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [DEV_W-1:0]   s_device_kind,
    input  wire logic [VER_W-1:0]   s_image_version,
    input  wire logic [ADDR_W-1:0]  s_addr_or_size,
    input  wire logic [WORD_W-1:0]  s_payload_lo,
    input  wire logic [WORD_W-1:0]  s_payload_hi,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output opw_cmd_t                cmd
);

    localparam int SB_W  = $clog2(SECTOR_BYTES);
    localparam int SEC_W = ADDR_W - SB_W;
    localparam int IDX_W = (MAP_SECTORS > 1) ? $clog2(MAP_SECTORS) : 1;

    typedef enum logic [2:0] {
        SESS_NONE = 3'b001,
        SESS_RECV = 3'b010,
        SESS_DONE = 3'b100
    } opw_sess_t;

    opw_sess_t              sess_reg, sess_next;
    logic [DEV_W-1:0]       dev_reg, dev_next;
    logic [VER_W-1:0]       ver_reg, ver_next;
    logic [MAP_SECTORS-1:0] map_reg, map_next;

    logic                   accept;
    logic                   is_begin, data_ok, end_ok;
    logic [SEC_W-1:0]       sector;
    logic [31:0]            sector_ext;
    logic                   in_map;
    logic [IDX_W-1:0]       map_idx;
    logic                   erase_hit;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    // packet checks against the open session
    assign is_begin = (s_req_type == REQ_BEGIN);
    assign data_ok  = (s_req_type == REQ_DATA) && (sess_reg == SESS_RECV) &&
                      (s_device_kind == dev_reg) && (s_image_version == ver_reg);
    assign end_ok   = (s_req_type == REQ_END) && (sess_reg == SESS_RECV);

    // sector lookup in the erase-pending map
    assign sector     = s_addr_or_size[ADDR_W-1:SB_W];
    assign sector_ext = {{(32-SEC_W){1'b0}}, sector};
    assign in_map     = (sector_ext < 32'(MAP_SECTORS));
    assign map_idx    = sector_ext[IDX_W-1:0];
    assign erase_hit  = in_map && map_reg[map_idx];

    // command record
    always_comb begin
        cmd.erase   = data_ok && erase_hit;
        cmd.addr    = s_addr_or_size;
        cmd.version = s_image_version;
        cmd.lo      = s_payload_lo;
        cmd.hi      = s_payload_hi;
        priority if (is_begin) begin
            cmd.op = OP_BEGIN;
        end else if (data_ok) begin
            cmd.op = OP_DATA;
        end else if (end_ok) begin
            cmd.op = OP_END;
        end else begin
            cmd.op = OP_REJECT;
        end
    end

    // session and map update on each accepted request
    always_comb begin
        sess_next = sess_reg;
        dev_next  = dev_reg;
        ver_next  = ver_reg;
        map_next  = map_reg;
        if (accept) begin
            if (is_begin || end_ok) begin
                sess_next = is_begin ? SESS_RECV : SESS_DONE;
                dev_next  = s_device_kind;
                ver_next  = s_image_version;
                if (end_ok) begin
                    map_next = '1;
                end
            end else if (data_ok && erase_hit) begin
                map_next[map_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_reg <= SESS_NONE;
            dev_reg  <= '0;
            ver_reg  <= '0;
            map_reg  <= '0;
        end else begin
            sess_reg <= sess_next;
            dev_reg  <= dev_next;
            ver_reg  <= ver_next;
            map_reg  <= map_next;
        end
    end

endmodule
`default_nettype wire

@@ design/opw_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opw_queue: short command queue between front and back
// lets intake and flash command issue stall independently
// ----------------------------------------------------------------------------
module opw_queue
    import opw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire opw_cmd_t push_data,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output opw_cmd_t      pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    opw_cmd_t           entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ design/opw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opw_back: flash command issue
// holds the address registers, forms flash addresses and drives the result
// ----------------------------------------------------------------------------
module opw_back
    import opw_pkg::*;
#(
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_index,
    input  wire logic [ADDR_W-1:0]        cfg_wdata,
    input  wire logic                     cmd_valid,
    output logic                          cmd_ready,
    input  wire opw_cmd_t                 cmd,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_status,
    output logic                          m_erase_now,
    output logic [FLASH_ADDR_W-1:0]       m_erase_addr,
    output logic                          m_write_now,
    output logic [FLASH_ADDR_W-1:0]       m_write_addr,
    output logic [WORD_W-1:0]             m_write_lo,
    output logic [WORD_W-1:0]             m_write_hi,
    output logic                          m_header_commit,
    output logic [VER_W-1:0]              m_header_version,
    output logic [ADDR_W-1:0]             m_header_size
);

    localparam int SB_W = $clog2(SECTOR_BYTES);

    logic [ADDR_W-1:0]       base_reg, hdr_reg;
    logic                    valid_reg, valid_next;
    logic                    status_reg, status_next;
    logic                    erase_reg, erase_next;
    logic [FLASH_ADDR_W-1:0] erase_addr_reg, erase_addr_next;
    logic                    write_reg, write_next;
    logic [FLASH_ADDR_W-1:0] write_addr_reg, write_addr_next;
    logic [WORD_W-1:0]       lo_reg, lo_next;
    logic [WORD_W-1:0]       hi_reg, hi_next;
    logic                    commit_reg, commit_next;
    logic [VER_W-1:0]        hver_reg, hver_next;
    logic [ADDR_W-1:0]       hsize_reg, hsize_next;

    logic                    load;
    logic [ADDR_W-1:0]       sector_off;
    logic [FLASH_ADDR_W-1:0] sector_addr, data_addr;

    // address registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            hdr_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_BASE: base_reg <= cfg_wdata;
                CFG_HEADER:     hdr_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // output register takes a new command when empty or drained
    assign cmd_ready = !valid_reg || m_ready;
    assign load      = cmd_valid && cmd_ready;

    // flash addresses relative to the image region
    assign sector_off  = {cmd.addr[ADDR_W-1:SB_W], {SB_W{1'b0}}};
    assign sector_addr = {1'b0, base_reg} + {1'b0, sector_off};
    assign data_addr   = {1'b0, base_reg} + {1'b0, cmd.addr};

    always_comb begin
        valid_next      = load ? 1'b1 : (valid_reg && !m_ready);
        status_next     = 1'b0;
        erase_next      = 1'b0;
        erase_addr_next = '0;
        write_next      = 1'b0;
        write_addr_next = '0;
        lo_next         = '0;
        hi_next         = '0;
        commit_next     = 1'b0;
        hver_next       = '0;
        hsize_next      = '0;
        unique case (cmd.op)
            OP_DATA: begin
                erase_next      = cmd.erase;
                erase_addr_next = cmd.erase ? sector_addr : '0;
                write_next      = 1'b1;
                write_addr_next = data_addr;
                lo_next         = cmd.lo;
                hi_next         = cmd.hi;
            end
            OP_END: begin
                erase_next      = 1'b1;
                erase_addr_next = {1'b0, hdr_reg};
                write_next      = 1'b1;
                write_addr_next = {1'b0, hdr_reg};
                lo_next         = cmd.lo;
                hi_next         = cmd.hi;
                commit_next     = 1'b1;
                hver_next       = cmd.version;
                hsize_next      = cmd.addr;
            end
            OP_BEGIN: begin
                status_next = 1'b0;
            end
            OP_REJECT: begin
                status_next = 1'b1;
            end
            default: begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg     <= status_next;
            erase_reg      <= erase_next;
            erase_addr_reg <= erase_addr_next;
            write_reg      <= write_next;
            write_addr_reg <= write_addr_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            commit_reg     <= commit_next;
            hver_reg       <= hver_next;
            hsize_reg      <= hsize_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_status         = status_reg;
    assign m_erase_now      = erase_reg;
    assign m_erase_addr     = erase_addr_reg;
    assign m_write_now      = write_reg;
    assign m_write_addr     = write_addr_reg;
    assign m_write_lo       = lo_reg;
    assign m_write_hi       = hi_reg;
    assign m_header_commit  = commit_reg;
    assign m_header_version = hver_reg;
    assign m_header_size    = hsize_reg;

endmodule
`default_nettype wire

@@ design/ota_packet_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ota_packet_writer: firmware update packet writer
// turns begin, data and end update packets into flash erase and write requests
// ----------------------------------------------------------------------------
// usage
// - s_ channel: one update packet per request (begin, data, end, unknown).
// - m_ channel: exactly one result per packet, in packet order: status plus
//   the flash erase and sixteen-byte write to issue, and the header fields.
// - cfg port: register 0 is the image base offset, register 1 the header
//   address; write only while no packet is in flight.
// - path: the front classifies each accepted packet and updates session and
//   erase map, the queue stores its command, and the back forms flash
//   addresses in the output register that drives the m_ channel.
// - throughput: one packet per cycle while the queue has room, set by the map
//   bit test and clear in the front.
// - a two-entry command queue sits between front and back; while the receiver
//   holds m_ready low, up to two packets wait in it behind the one held in the
//   output register, then s_ready drops until a result is taken.
// - reset: no session open, erase map all zeros, both address registers zero,
//   queue and output register empty.
// ----------------------------------------------------------------------------
module ota_packet_writer
    import opw_pkg::*;
#(
    parameter int SECTOR_BYTES = 4096,
    parameter int MAP_SECTORS  = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_index,
    input  wire logic [ADDR_W-1:0]        cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_req_type,
    input  wire logic [DEV_W-1:0]         s_device_kind,
    input  wire logic [VER_W-1:0]         s_image_version,
    input  wire logic [ADDR_W-1:0]        s_addr_or_size,
    input  wire logic [WORD_W-1:0]        s_payload_lo,
    input  wire logic [WORD_W-1:0]        s_payload_hi,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_status,
    output logic                          m_erase_now,
    output logic [FLASH_ADDR_W-1:0]       m_erase_addr,
    output logic                          m_write_now,
    output logic [FLASH_ADDR_W-1:0]       m_write_addr,
    output logic [WORD_W-1:0]             m_write_lo,
    output logic [WORD_W-1:0]             m_write_hi,
    output logic                          m_header_commit,
    output logic [VER_W-1:0]              m_header_version,
    output logic [ADDR_W-1:0]             m_header_size
);

    logic     front_valid, front_ready;
    opw_cmd_t front_cmd;
    logic     back_valid, back_ready;
    opw_cmd_t back_cmd;

    // intake and classification
    opw_front #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .MAP_SECTORS  (MAP_SECTORS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_device_kind   (s_device_kind),
        .s_image_version (s_image_version),
        .s_addr_or_size  (s_addr_or_size),
        .s_payload_lo    (s_payload_lo),
        .s_payload_hi    (s_payload_hi),
        .cmd_valid       (front_valid),
        .cmd_ready       (front_ready),
        .cmd             (front_cmd)
    );

    // command queue
    opw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    // flash request issue
    opw_back #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .cmd_valid        (back_valid),
        .cmd_ready        (back_ready),
        .cmd              (back_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_erase_now      (m_erase_now),
        .m_erase_addr     (m_erase_addr),
        .m_write_now      (m_write_now),
        .m_write_addr     (m_write_addr),
        .m_write_lo       (m_write_lo),
        .m_write_hi       (m_write_hi),
        .m_header_commit  (m_header_commit),
        .m_header_version (m_header_version),
        .m_header_size    (m_header_size)
    );

endmodule
`default_nettype wire

@@ design/opw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opw_checker: port-level checks of the update packet writer
// result consistency and output stall behaviour, bound to the top level
// ----------------------------------------------------------------------------
module opw_checker
    import opw_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic                     m_status,
    input wire logic                     m_erase_now,
    input wire logic [FLASH_ADDR_W-1:0]  m_erase_addr,
    input wire logic                     m_write_now,
    input wire logic [FLASH_ADDR_W-1:0]  m_write_addr,
    input wire logic                     m_header_commit
);

    // no result straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds its flash request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_addr) && $stable(m_erase_now))
        else $error("stalled result changed");

    // a rejected packet issues no flash request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_erase_now && !m_write_now && !m_header_commit)
        else $error("rejected packet issued flash request");

    // header commit erases and writes the same address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_header_commit |->
            m_erase_now && m_write_now && (m_erase_addr == m_write_addr))
        else $error("header commit inconsistent");

    // an erase always comes with a write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_erase_now |-> m_write_now)
        else $error("erase without write");

endmodule

bind ota_packet_writer opw_checker u_opw_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_erase_now     (m_erase_now),
    .m_erase_addr    (m_erase_addr),
    .m_write_now     (m_write_now),
    .m_write_addr    (m_write_addr),
    .m_header_commit (m_header_commit)
);
`default_nettype wire

@@ verif/ota_packet_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_packet_writer_tb: self-checking bench for the update packet writer
// drives begin, data and end packets with random gaps on both channels,
// predicts each flash erase and write request and checks every result in order
// ----------------------------------------------------------------------------
module ota_packet_writer_tb;
    import opw_pkg::*;

    localparam int SECTOR_BYTES = 4096;
    localparam int MAP_SECTORS  = 128;
    localparam int MAP_IDX_W    = $clog2(MAP_SECTORS);
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        SESS_NONE = 2'd0,
        SESS_RECV = 2'd1,
        SESS_DONE = 2'd2
    } session_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DEV_W-1:0]  dev;
        logic [VER_W-1:0]  ver;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
    } packet_t;

    typedef struct packed {
        logic                    status;
        logic                    erase_now;
        logic [FLASH_ADDR_W-1:0] erase_addr;
        logic                    write_now;
        logic [FLASH_ADDR_W-1:0] write_addr;
        logic [WORD_W-1:0]       write_lo;
        logic [WORD_W-1:0]       write_hi;
        logic                    header_commit;
        logic [VER_W-1:0]        header_version;
        logic [ADDR_W-1:0]       header_size;
    } flash_cmd_t;

    // clock, reset and block ports
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic                    cfg_index = 1'b0;
    logic [ADDR_W-1:0]       cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_req_type = '0;
    logic [DEV_W-1:0]        s_device_kind = '0;
    logic [VER_W-1:0]        s_image_version = '0;
    logic [ADDR_W-1:0]       s_addr_or_size = '0;
    logic [WORD_W-1:0]       s_payload_lo = '0;
    logic [WORD_W-1:0]       s_payload_hi = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_status;
    logic                    m_erase_now;
    logic [FLASH_ADDR_W-1:0] m_erase_addr;
    logic                    m_write_now;
    logic [FLASH_ADDR_W-1:0] m_write_addr;
    logic [WORD_W-1:0]       m_write_lo;
    logic [WORD_W-1:0]       m_write_hi;
    logic                    m_header_commit;
    logic [VER_W-1:0]        m_header_version;
    logic [ADDR_W-1:0]       m_header_size;

    // predicted writer state and register copies
    session_t                sess_state = SESS_NONE;
    logic [DEV_W-1:0]        sess_dev = '0;
    logic [VER_W-1:0]        sess_ver = '0;
    logic [ADDR_W-1:0]       sess_size = '0;
    logic [WORD_W-1:0]       sess_sig_lo = '0;
    logic [WORD_W-1:0]       sess_sig_hi = '0;
    logic [MAP_SECTORS-1:0]  erase_pending = '0;
    logic [ADDR_W-1:0]       image_base = '0;
    logic [ADDR_W-1:0]       header_base = '0;

    // stimulus and checking state
    packet_t                 packet_queue[$];
    flash_cmd_t              flash_cmd_expect[$];
    packet_t                 on_wire;
    flash_cmd_t              got_cmd;
    flash_cmd_t              want_cmd;
    int unsigned             queued_items = 0;
    int unsigned             mismatch_count = 0;
    int unsigned             send_gap = 0;
    int unsigned             recv_gap = 0;
    int unsigned             recv_pick;
    int unsigned             send_idle_pct = 0;
    int unsigned             recv_idle_pct = 0;
    int unsigned             cycle_count = 0;
    int unsigned             hold_cycles = 0;
    logic                    hold_armed = 1'b0;
    logic                    long_hold;

    ota_packet_writer #(
        .SECTOR_BYTES(SECTOR_BYTES),
        .MAP_SECTORS (MAP_SECTORS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_device_kind   (s_device_kind),
        .s_image_version (s_image_version),
        .s_addr_or_size  (s_addr_or_size),
        .s_payload_lo    (s_payload_lo),
        .s_payload_hi    (s_payload_hi),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_erase_now     (m_erase_now),
        .m_erase_addr    (m_erase_addr),
        .m_write_now     (m_write_now),
        .m_write_addr    (m_write_addr),
        .m_write_lo      (m_write_lo),
        .m_write_hi      (m_write_hi),
        .m_header_commit (m_header_commit),
        .m_header_version(m_header_version),
        .m_header_size   (m_header_size)
    );

    always #5 aclk = ~aclk;

    // flash request predicted for one packet, updating session and erase map
    function automatic flash_cmd_t predict_flash_cmd(input packet_t p);
        flash_cmd_t           r;
        int unsigned          sector;
        logic [MAP_IDX_W-1:0] map_idx;
        r = '0;
        sector = p.addr / SECTOR_BYTES;
        map_idx = sector[MAP_IDX_W-1:0];
        if (p.kind == REQ_BEGIN) begin
            sess_dev    = p.dev;
            sess_ver    = p.ver;
            sess_size   = p.addr;
            sess_sig_lo = p.lo;
            sess_sig_hi = p.hi;
            sess_state  = SESS_RECV;
        end else if (p.kind == REQ_DATA && sess_state == SESS_RECV &&
                     p.dev == sess_dev && p.ver == sess_ver) begin
            // first write into a pending sector erases it
            if (sector < MAP_SECTORS && erase_pending[map_idx]) begin
                erase_pending[map_idx] = 1'b0;
                r.erase_now  = 1'b1;
                r.erase_addr = FLASH_ADDR_W'(image_base + sector * SECTOR_BYTES);
            end
            r.write_now  = 1'b1;
            r.write_addr = {1'b0, image_base} + {1'b0, p.addr};
            r.write_lo   = p.lo;
            r.write_hi   = p.hi;
        end else if (p.kind == REQ_END && sess_state == SESS_RECV) begin
            // header commit carries the end packet's own fields
            sess_dev    = p.dev;
            sess_ver    = p.ver;
            sess_size   = p.addr;
            sess_sig_lo = p.lo;
            sess_sig_hi = p.hi;
            sess_state  = SESS_DONE;
            r.erase_now      = 1'b1;
            r.erase_addr     = {1'b0, header_base};
            r.write_now      = 1'b1;
            r.write_addr     = {1'b0, header_base};
            r.write_lo       = sess_sig_lo;
            r.write_hi       = sess_sig_hi;
            r.header_commit  = 1'b1;
            r.header_version = sess_ver;
            r.header_size    = sess_size;
            erase_pending    = '1;
        end else begin
            r.status = 1'b1;
        end
        return r;
    endfunction

    // idle length: mostly none, sometimes short, rarely long
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic add_packet(input logic [1:0] kind, input logic [DEV_W-1:0] dev,
                              input logic [VER_W-1:0] ver,
                              input logic [ADDR_W-1:0] addr,
                              input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        packet_t p;
        p.kind = kind;
        p.dev  = dev;
        p.ver  = ver;
        p.addr = addr;
        p.lo   = lo;
        p.hi   = hi;
        packet_queue.push_back(p);
        queued_items++;
    endtask

    // one update session with random content, sometimes broken
    task automatic add_session();
        logic [DEV_W-1:0]  dev;
        logic [VER_W-1:0]  ver;
        logic [ADDR_W-1:0] addr;
        int unsigned       n;
        int unsigned       roll;
        dev = DEV_W'($urandom);
        ver = VER_W'($urandom);
        n   = $urandom_range(1, 24);
        add_packet(REQ_BEGIN, dev, ver, ADDR_W'($urandom), rand_word(), rand_word());
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                addr = ADDR_W'($urandom_range(0, MAP_SECTORS * SECTOR_BYTES - 1));
                add_packet(REQ_DATA, dev, ver, addr, rand_word(), rand_word());
            end else if (roll < 85) begin
                add_packet(REQ_DATA, dev, ver, ADDR_W'($urandom), rand_word(),
                           rand_word());
            end else if (roll < 90) begin
                add_packet(REQ_DATA, dev ^ 8'($urandom_range(1, 255)), ver,
                           ADDR_W'($urandom), rand_word(), rand_word());
            end else if (roll < 95) begin
                add_packet(REQ_DATA, dev, ver ^ 8'($urandom_range(1, 255)),
                           ADDR_W'($urandom), rand_word(), rand_word());
            end else begin
                add_packet(REQ_UNKNOWN, DEV_W'($urandom), VER_W'($urandom),
                           ADDR_W'($urandom), rand_word(), rand_word());
            end
        end
        // most sessions close; a few are left open or overrun
        if ($urandom_range(0, 99) < 85)
            add_packet(REQ_END, DEV_W'($urandom), VER_W'($urandom), ADDR_W'($urandom),
                       rand_word(), rand_word());
        if ($urandom_range(0, 9) == 0)
            add_packet(REQ_DATA, dev, ver, ADDR_W'($urandom), rand_word(), rand_word());
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IMAGE_BASE)
            image_base = value;
        else
            header_base = value;
    endtask

    task automatic wait_idle();
        while (packet_queue.size() != 0 || s_valid || flash_cmd_expect.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // random phase: new registers and idling, then sessions and noise
    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] hdr,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned items, input logic with_hold);
        int unsigned target;
        wait_idle();
        write_reg(CFG_IMAGE_BASE, base);
        write_reg(CFG_HEADER, hdr);
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = queued_items + items;
        while (queued_items < target) begin
            if ($urandom_range(0, 9) == 0)
                add_packet(2'($urandom_range(0, 3)), DEV_W'($urandom), VER_W'($urandom),
                           ADDR_W'($urandom), rand_word(), rand_word());
            else
                add_session();
        end
        if (with_hold)
            hold_armed = 1'b1;
    endtask

    // one long receiver hold-off once armed
    always @(posedge aclk) begin
        if (hold_armed && hold_cycles < LONG_HOLD)
            hold_cycles <= hold_cycles + 1;
    end
    assign long_hold = hold_armed && hold_cycles < LONG_HOLD;

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                flash_cmd_expect.push_back(predict_flash_cmd(on_wire));
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (packet_queue.size() != 0) begin
                    on_wire = packet_queue.pop_front();
                    s_valid         <= 1'b1;
                    s_req_type      <= on_wire.kind;
                    s_device_kind   <= on_wire.dev;
                    s_image_version <= on_wire.ver;
                    s_addr_or_size  <= on_wire.addr;
                    s_payload_lo    <= on_wire.lo;
                    s_payload_hi    <= on_wire.hi;
                    send_gap        <= pick_gap(send_idle_pct);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // result monitor and ready generation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got_cmd = '{m_status, m_erase_now, m_erase_addr, m_write_now,
                            m_write_addr, m_write_lo, m_write_hi, m_header_commit,
                            m_header_version, m_header_size};
                if (flash_cmd_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with no request waiting: %h", got_cmd);
                end else begin
                    want_cmd = flash_cmd_expect.pop_front();
                    check_field("status", WORD_W'(got_cmd.status),
                                WORD_W'(want_cmd.status));
                    check_field("erase_now", WORD_W'(got_cmd.erase_now),
                                WORD_W'(want_cmd.erase_now));
                    check_field("erase_addr", WORD_W'(got_cmd.erase_addr),
                                WORD_W'(want_cmd.erase_addr));
                    check_field("write_now", WORD_W'(got_cmd.write_now),
                                WORD_W'(want_cmd.write_now));
                    check_field("write_addr", WORD_W'(got_cmd.write_addr),
                                WORD_W'(want_cmd.write_addr));
                    check_field("write_lo", got_cmd.write_lo, want_cmd.write_lo);
                    check_field("write_hi", got_cmd.write_hi, want_cmd.write_hi);
                    check_field("header_commit", WORD_W'(got_cmd.header_commit),
                                WORD_W'(want_cmd.header_commit));
                    check_field("header_version", WORD_W'(got_cmd.header_version),
                                WORD_W'(want_cmd.header_version));
                    check_field("header_size", WORD_W'(got_cmd.header_size),
                                WORD_W'(want_cmd.header_size));
                end
            end
            if (recv_gap != 0) begin
                m_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (long_hold) begin
                m_ready <= 1'b0;
            end else begin
                recv_pick = pick_gap(recv_idle_pct);
                m_ready  <= (recv_pick == 0);
                recv_gap <= (recv_pick == 0) ? 0 : recv_pick - 1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ota_packet_writer test failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: rejects with no session, then a full session
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'h000000, 64'h0, 64'h0);
        add_packet(REQ_END, 8'h00, 8'h00, 24'h000000, 64'h0, 64'h0);
        add_packet(REQ_UNKNOWN, 8'hFF, 8'hFF, 24'hFFFFFF, '1, '1);
        add_packet(REQ_BEGIN, 8'hFF, 8'hFF, 24'hFFFFFF, '1, '1);
        add_packet(REQ_DATA, 8'hFF, 8'hFF, 24'h000000,
                   64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        add_packet(REQ_DATA, 8'hFE, 8'hFF, 24'h000010, '1, '1);
        add_packet(REQ_DATA, 8'hFF, 8'h7F, 24'h000020, '1, '1);
        add_packet(REQ_END, 8'h5A, 8'h12, 24'h000123,
                   64'hA5A5_5A5A_0F0F_F0F0, 64'h1122_3344_5566_7788);
        // completed session rejects data and a second end
        add_packet(REQ_DATA, 8'h5A, 8'h12, 24'h000000, '1, '1);
        add_packet(REQ_END, 8'h5A, 8'h12, 24'h000123, '1, '1);
        // erase map now full: first write per sector erases
        add_packet(REQ_BEGIN, 8'h00, 8'h00, 24'h000000, 64'h0, 64'h0);
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'h000010, 64'h1, 64'h2);
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'h000FF0, 64'h3, 64'h4);
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'h07FFF0, 64'h5, 64'h6);
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'h080000, 64'h7, 64'h8);
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'hFFFFFF, 64'h9, 64'hA);
        // begin in mid-session replaces it
        add_packet(REQ_BEGIN, 8'h33, 8'h44, 24'h00F000, '1, 64'h0);
        add_packet(REQ_DATA, 8'h00, 8'h00, 24'h000000, 64'h0, 64'h0);
        add_packet(REQ_DATA, 8'h33, 8'h44, 24'h001000, 64'hB, 64'hC);

        // addresses at the top of both registers, carrying into the top flash address bit
        wait_idle();
        write_reg(CFG_IMAGE_BASE, 24'hFFFFFF);
        write_reg(CFG_HEADER, 24'hFFFFFF);
        @(negedge aclk);
        add_packet(REQ_DATA, 8'h33, 8'h44, 24'hFFFFFF, 64'hD, 64'hE);
        add_packet(REQ_DATA, 8'h33, 8'h44, 24'h002000, 64'hF, 64'h10);
        add_packet(REQ_END, 8'h33, 8'h44, 24'h00F000, '1, 64'h0);
        add_packet(REQ_UNKNOWN, 8'h00, 8'h00, 24'h000000, 64'h0, 64'h0);

        // random sessions under changing registers and idling
        run_phase(24'h000000, 24'h000000, 0, 0, 340, 1'b0);
        run_phase(ADDR_W'($urandom), ADDR_W'($urandom), 30, 30, 340, 1'b1);
        run_phase(24'hFFFFFF, ADDR_W'($urandom), 60, 20, 330, 1'b0);
        run_phase(ADDR_W'($urandom), 24'hFFFFFF, 20, 60, 330, 1'b0);

        wait_idle();
        if (mismatch_count == 0 && flash_cmd_expect.size() == 0)
            $display("ota_packet_writer test passed");
        else
            $display("ota_packet_writer test failed");
        $finish;
    end

endmodule

@@ ota_packet_writer.f @@
design/opw_pkg.sv
design/opw_front.sv
design/opw_queue.sv
design/opw_back.sv
design/ota_packet_writer.sv
design/opw_checker.sv
verif/ota_packet_writer_tb.sv
